### rtl/complex_arithmetic_unit_top_assert.svh
// Assertion macros shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define CAU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never be true outside reset.
`define CAU_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### rtl/cau_pkg.sv
`timescale 1ns / 1ps
package cau_pkg;
	localparam int FracBitsDefault = 8;
	localparam int DataW = 16;
	localparam int QueueDepth = 4;

	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;
	localparam logic [2:0] KIND_CMP = 3'd4;

	// Classified item passed from the front end to the back end.
	typedef struct packed {
		logic              is_add;
		logic              is_sub;
		logic              is_mul;
		logic              is_div;
		logic              is_equal;
		logic              div_zero;
		logic signed [15:0] a_real;
		logic signed [15:0] a_imag;
		logic signed [15:0] b_real;
		logic signed [15:0] b_imag;
	} cau_op_t;

	typedef struct packed {
		logic signed [15:0] r_real;
		logic signed [15:0] r_imag;
		logic               is_equal;
		logic               div_zero;
		logic               overflow;
	} cau_res_t;
endpackage

### rtl/complex_arithmetic_unit_top.sv
// Path from input transfer to output valid: front queue, two product stages, 17-stage
// divider and output queue.
// Accepts one item per cycle while output credits remain; the output queue absorbs stalls without losing items.
// Input ready drops only when the front queue is full, once all output credits are in use.
// Reset: arst_n clears all queue pointers and valid flags asynchronously.
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_top_assert.svh"
module complex_arithmetic_unit_top #(
	parameter int FRAC_BITS = cau_pkg::FracBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,  // kind
	input  logic [63:0] s_tdata,  // a_real, a_imag, b_real, b_imag
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // r_real, r_imag
	output logic [2:0]  m_tuser   // is_equal, div_zero, overflow
);
	logic              op_valid, op_ready;
	cau_pkg::cau_op_t  op;
	cau_pkg::cau_res_t res;

	cau_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.kind(s_tuser), .a_real(s_tdata[15:0]), .a_imag(s_tdata[31:16]),
		.b_real(s_tdata[47:32]), .b_imag(s_tdata[63:48]),
		.op_valid(op_valid), .op_ready(op_ready), .op(op));

	cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .op_valid(op_valid), .op_ready(op_ready),
		.op(op), .res_valid(m_tvalid), .res_ready(m_tready), .res(res));

	assign m_tdata = {res.r_imag, res.r_real};
	assign m_tuser = {res.overflow, res.div_zero, res.is_equal};

	`CAU_ASSERT_NEVER(a_flags_excl, m_tvalid && (m_tuser[0] + m_tuser[1] + m_tuser[2] > 2'd1), "result flags overlap")
	`CAU_ASSERT_IMP(a_dz_zero, m_tvalid && m_tuser[1], m_tdata == 32'd0, "div_zero with nonzero result")
	`CAU_ASSERT_IMP(a_eq_zero, m_tvalid && m_tuser[0], m_tdata == 32'd0, "compare with nonzero result")
endmodule

### rtl/cau_front.sv
`timescale 1ns / 1ps
// Decodes the operation, checks compare and zero divisor, and feeds a short queue.
module cau_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          kind,
	input  logic signed [15:0]  a_real,
	input  logic signed [15:0]  a_imag,
	input  logic signed [15:0]  b_real,
	input  logic signed [15:0]  b_imag,
	output logic                op_valid,
	input  logic                op_ready,
	output cau_pkg::cau_op_t    op
);
	localparam int AW = $clog2(cau_pkg::QueueDepth);

	cau_pkg::cau_op_t mem_q [cau_pkg::QueueDepth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	cau_pkg::cau_op_t cls;
	logic push, pop;

	always_comb begin
		cls.is_add   = (kind == cau_pkg::KIND_ADD);
		cls.is_sub   = (kind == cau_pkg::KIND_SUB);
		cls.is_mul   = (kind == cau_pkg::KIND_MUL);
		cls.is_div   = (kind == cau_pkg::KIND_DIV) && ((b_real != '0) || (b_imag != '0));
		cls.div_zero = (kind == cau_pkg::KIND_DIV) && (b_real == '0) && (b_imag == '0);
		cls.is_equal = (kind == cau_pkg::KIND_CMP) && (a_real == b_real) && (a_imag == b_imag);
		cls.a_real   = a_real;
		cls.a_imag   = a_imag;
		cls.b_real   = b_real;
		cls.b_imag   = b_imag;
	end

	assign in_ready = (cnt_q != (AW+1)'(cau_pkg::QueueDepth));
	assign op_valid = (cnt_q != '0);
	assign push = in_valid && in_ready;
	assign pop  = op_valid && op_ready;
	assign op   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

### rtl/cau_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// only needed up to the saturation bound, so QW bits are produced.
module cau_divider #(
	parameter int NW = 48,
	parameter int DW = 33,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic          big_in,
	output logic [QW-1:0] quo,
	output logic          big_out
);
	// big flags a quotient that is known to be at least 2^QW.
	logic [NW-1:0] rem_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [QW-1:0] q_s    [QW+1];
	logic          big_s  [QW+1];

	always_comb begin
		rem_s[0] = num;
		den_s[0] = den;
		q_s[0]   = '0;
		big_s[0] = big_in;
	end

	for (genvar i = 0; i < QW; i++) begin : g_st
		localparam int SH = QW - 1 - i;
		logic [NW+QW-1:0] trial;
		assign trial = (NW+QW)'(den_s[i]) << SH;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= den_s[i];
				big_s[i+1] <= big_s[i];
				if ({{QW{1'b0}}, rem_s[i]} >= trial) begin
					rem_s[i+1] <= rem_s[i] - trial[NW-1:0];
					q_s[i+1]   <= q_s[i] | (QW'(1) << SH);
				end else begin
					rem_s[i+1] <= rem_s[i];
					q_s[i+1]   <= q_s[i];
				end
			end
		end
	end

	assign quo     = q_s[QW];
	assign big_out = big_s[QW];
endmodule

### rtl/cau_back.sv
`timescale 1ns / 1ps
// Execution pipeline: products, divider, rescale, saturation and output queue.
module cau_back #(
	parameter int FRAC_BITS = cau_pkg::FracBitsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_ready,
	input  cau_pkg::cau_op_t  op,
	output logic              res_valid,
	input  logic              res_ready,
	output cau_pkg::cau_res_t res
);
	localparam int QW   = 17;
	localparam int NW   = 33 + FRAC_BITS;
	localparam int DEP  = QW + 3;
	localparam int FIFO = DEP + 2;
	localparam int FAW  = $clog2(FIFO);

	// Stall-free pipeline; credits keep the output queue from overflowing.
	logic [FAW:0] cred_q;
	logic         pop_res, take;

	assign op_ready = (cred_q != '0);
	assign take     = op_valid && op_ready;

	// Stage 1: the four products and the add/subtract sums.
	logic signed [31:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [16:0] sum_r_s1, sum_i_s1;
	cau_pkg::cau_op_t   op_s1;
	logic               v_s1;

	always_ff @(posedge clk) begin
		p_rr_s1 <= op.a_real * op.b_real;
		p_ii_s1 <= op.a_imag * op.b_imag;
		p_ri_s1 <= op.a_real * op.b_imag;
		p_ir_s1 <= op.a_imag * op.b_real;
		sum_r_s1 <= op.is_sub ? (17'(op.a_real) - 17'(op.b_real))
			: (17'(op.a_real) + 17'(op.b_real));
		sum_i_s1 <= op.is_sub ? (17'(op.a_imag) - 17'(op.b_imag))
			: (17'(op.a_imag) + 17'(op.b_imag));
		op_s1 <= op;
	end

	// Stage 2: divisor squares and combined sums.
	logic signed [32:0] mre_s2, mim_s2, nre_s2, nim_s2;
	logic        [32:0] den_s2;
	logic signed [16:0] sum_r_s2, sum_i_s2;
	cau_pkg::cau_op_t   op_s2;
	logic               v_s2;
	logic signed [31:0] br2, bi2;
	assign br2 = op_s1.b_real * op_s1.b_real;
	assign bi2 = op_s1.b_imag * op_s1.b_imag;

	always_ff @(posedge clk) begin
		mre_s2 <= 33'(p_rr_s1) - 33'(p_ii_s1);
		mim_s2 <= 33'(p_ri_s1) + 33'(p_ir_s1);
		nre_s2 <= 33'(p_rr_s1) + 33'(p_ii_s1);
		nim_s2 <= 33'(p_ir_s1) - 33'(p_ri_s1);
		den_s2 <= 33'(unsigned'(br2)) + 33'(unsigned'(bi2));
		sum_r_s2 <= sum_r_s1;
		sum_i_s2 <= sum_i_s1;
		op_s2 <= op_s1;
	end

	// Stage 3: everything but division resolves here, division magnitudes go in.
	logic [NW-1:0] mag_r, mag_i;
	logic [32:0]   abs_r, abs_i;
	assign abs_r = nre_s2[32] ? 33'(-nre_s2) : nre_s2;
	assign abs_i = nim_s2[32] ? 33'(-nim_s2) : nim_s2;
	assign mag_r = NW'(abs_r) << FRAC_BITS;
	assign mag_i = NW'(abs_i) << FRAC_BITS;

	logic signed [33:0] rnd_r, rnd_i;
	always_comb begin
		if (FRAC_BITS == 0) begin
			rnd_r = 34'(mre_s2);
			rnd_i = 34'(mim_s2);
		end else begin
			rnd_r = (34'(mre_s2) + (34'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
			rnd_i = (34'(mim_s2) + (34'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		end
	end

	logic signed [33:0] pre_r, pre_i;
	always_comb begin
		priority if (op_s2.is_mul) begin
			pre_r = rnd_r;
			pre_i = rnd_i;
		end else if (op_s2.is_add || op_s2.is_sub) begin
			pre_r = 34'(sum_r_s2);
			pre_i = 34'(sum_i_s2);
		end else begin
			pre_r = '0;
			pre_i = '0;
		end
	end

	// Non-divide results ride alongside the divider.
	logic signed [33:0] pr_d [DEP];
	cau_pkg::cau_op_t   op_d [DEP];
	logic               sr_d [DEP];
	logic               si_d [DEP];
	logic               v_d  [DEP];
	logic [QW-1:0] qr, qi;
	logic          bq_r, bq_i;

	cau_divider #(.NW(NW), .DW(33), .QW(QW)) u_div_r (
		.clk(clk), .en(1'b1), .num(mag_r), .den(den_s2), .big_in(1'b0),
		.quo(qr), .big_out(bq_r));
	cau_divider #(.NW(NW), .DW(33), .QW(QW)) u_div_i (
		.clk(clk), .en(1'b1), .num(mag_i), .den(den_s2), .big_in(1'b0),
		.quo(qi), .big_out(bq_i));

	logic signed [33:0] pi_d [DEP];
	always_ff @(posedge clk) begin
		pr_d[0] <= pre_r;
		pi_d[0] <= pre_i;
		op_d[0] <= op_s2;
		sr_d[0] <= nre_s2[32];
		si_d[0] <= nim_s2[32];
		for (int k = 1; k < DEP; k++) begin
			pr_d[k] <= pr_d[k-1];
			pi_d[k] <= pi_d[k-1];
			op_d[k] <= op_d[k-1];
			sr_d[k] <= sr_d[k-1];
			si_d[k] <= si_d[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < DEP; k++) v_d[k] <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_d[0] <= v_s2;
			v_d[1] <= v_d[0];
			for (int k = 2; k < DEP; k++) v_d[k] <= v_d[k-1];
		end
	end

	// Divider output lines up with tap QW-1 of the side line.
	localparam int TAP = QW - 1;
	logic signed [33:0] fin_r, fin_i;
	always_comb begin
		if (op_d[TAP].is_div) begin
			fin_r = sr_d[TAP] ? -34'(qr) : 34'(qr);
			fin_i = si_d[TAP] ? -34'(qi) : 34'(qi);
		end else begin
			fin_r = pr_d[TAP];
			fin_i = pi_d[TAP];
		end
	end

	function automatic logic [16:0] sat(input logic signed [33:0] x);
		if (x > 34'sd32767) return {1'b1, 16'h7FFF};
		if (x < -34'sd32768) return {1'b1, 16'h8000};
		return {1'b0, x[15:0]};
	endfunction

	logic [16:0] s_r, s_i;
	assign s_r = sat(fin_r);
	assign s_i = sat(fin_i);

	cau_pkg::cau_res_t res_new;
	always_comb begin
		res_new.r_real   = s_r[15:0];
		res_new.r_imag   = s_i[15:0];
		res_new.is_equal = op_d[TAP].is_equal;
		res_new.div_zero = op_d[TAP].div_zero;
		res_new.overflow = s_r[16] | s_i[16];
	end

	// Output queue sized to hold every item in flight.
	cau_pkg::cau_res_t oq_q [FIFO];
	logic [FAW-1:0] ow_q, or_q;
	logic [FAW:0]   ocnt_q;
	logic           push_res;
	assign push_res  = v_d[TAP];
	assign res_valid = (ocnt_q != '0);
	assign pop_res   = res_valid && res_ready;
	assign res       = oq_q[or_q];

	always_ff @(posedge clk) begin
		if (push_res) oq_q[ow_q] <= res_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q   <= '0;
			or_q   <= '0;
			ocnt_q <= '0;
			cred_q <= (FAW+1)'(FIFO);
		end else begin
			if (push_res) ow_q <= (ow_q == FAW'(FIFO - 1)) ? '0 : ow_q + 1'b1;
			if (pop_res) or_q <= (or_q == FAW'(FIFO - 1)) ? '0 : or_q + 1'b1;
			ocnt_q <= ocnt_q + (FAW+1)'(push_res) - (FAW+1)'(pop_res);
			cred_q <= cred_q - (FAW+1)'(take) + (FAW+1)'(pop_res);
		end
	end

	logic unused_b;
	assign unused_b = bq_r ^ bq_i;
endmodule

### tb/complex_arithmetic_unit_top_tb.sv
`timescale 1ns / 1ps
module complex_arithmetic_unit_top_tb;
	localparam int FRAC = 8;
	localparam int LATENCY = 21;
	localparam int IDLE_LIMIT = 2000;
	localparam logic [2:0] KIND_UNUSED = 3'd5;
	localparam logic [2:0] KIND_UNUSED_B = 3'd6;
	localparam logic [2:0] KIND_UNUSED_C = 3'd7;

	typedef struct {
		logic [2:0] kind;
		logic signed [15:0] ar, ai, br, bi;
	} operand_pair_t;

	typedef struct {
		logic signed [15:0] re, im;
		logic eq, dz, ovf;
	} complex_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [2:0] s_tuser;
	logic [63:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic [2:0] m_tuser;

	operand_pair_t pending_ops[$];
	complex_result_t expected_results[$];
	bit stimulus_done;
	bit failed;
	bit in_fire;
	bit out_fire;
	int idle_cycles;
	int send_gap;
	int recv_gap;
	int hold_off;
	bit hold_armed;

	complex_arithmetic_unit_top #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint saturate(input longint v, inout bit ovf);
		if (v > 32767) begin
			ovf = 1'b1;
			return 32767;
		end
		if (v < -32768) begin
			ovf = 1'b1;
			return -32768;
		end
		return v;
	endfunction

	// Round to nearest with ties toward plus infinity; >>> on longint is a floor.
	function automatic longint scale_product(input longint v);
		return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic longint quotient_toward_zero(input longint n, input longint d);
		longint mag;
		longint q;
		mag = (n < 0) ? -n : n;
		q = (mag <<< FRAC) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic complex_result_t complex_op_result(input operand_pair_t op);
		complex_result_t r;
		longint ar, ai, br, bi, re, im, d;
		bit ovf;
		ar = op.ar;
		ai = op.ai;
		br = op.br;
		bi = op.bi;
		re = 0;
		im = 0;
		ovf = 1'b0;
		r.eq = 1'b0;
		r.dz = 1'b0;
		case (op.kind)
			cau_pkg::KIND_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			cau_pkg::KIND_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			cau_pkg::KIND_MUL: begin
				re = scale_product(ar * br - ai * bi);
				im = scale_product(ar * bi + ai * br);
			end
			cau_pkg::KIND_DIV: begin
				d = br * br + bi * bi;
				if (d == 0) begin
					r.dz = 1'b1;
				end else begin
					re = quotient_toward_zero(ar * br + ai * bi, d);
					im = quotient_toward_zero(ai * br - ar * bi, d);
				end
			end
			cau_pkg::KIND_CMP: begin
				r.eq = (ar == br) && (ai == bi);
			end
			default: begin
			end
		endcase
		re = saturate(re, ovf);
		im = saturate(im, ovf);
		r.re = re[15:0];
		r.im = im[15:0];
		r.ovf = ovf;
		return r;
	endfunction

	// Driver: after each transfer the next item goes out at a falling edge once a random gap, possibly zero, has elapsed.
	always @(negedge clk) begin
		operand_pair_t op;
		if (arst_n) begin
			if (in_fire) begin
				void'(pending_ops.pop_front());
				send_gap = $urandom_range(0, 9);
				if ($urandom_range(0, 3) == 0) send_gap = 0;
			end
			if (!s_tvalid || in_fire) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					op = pending_ops[0];
					s_tvalid <= 1'b1;
					s_tuser <= op.kind;
					s_tdata <= {op.bi, op.br, op.ai, op.ar};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_armed && pending_ops.size() > 0 && pending_ops.size() < 1500) begin
				hold_armed = 1'b1;
				hold_off = 300;
			end
			if (hold_off > 0) begin
				hold_off--;
				m_tready <= 1'b0;
			end else if (out_fire) begin
				recv_gap = $urandom_range(0, 9);
				if ($urandom_range(0, 3) == 0) recv_gap = 0;
				m_tready <= (recv_gap == 0);
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= (recv_gap == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: predictions are made on accepted input transfers and checked on output transfers.
	always @(posedge clk) begin
		operand_pair_t op;
		complex_result_t want;
		in_fire = 1'b0;
		out_fire = 1'b0;
		if (arst_n) begin
			in_fire = s_tvalid && s_tready;
			out_fire = m_tvalid && m_tready;
			if (in_fire) begin
				op.kind = s_tuser;
				op.ar = s_tdata[15:0];
				op.ai = s_tdata[31:16];
				op.br = s_tdata[47:32];
				op.bi = s_tdata[63:48];
				expected_results.push_back(complex_op_result(op));
			end
			if (out_fire) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result re=%h im=%h flags=%b", $time,
						m_tdata[15:0], m_tdata[31:16], m_tuser);
					failed = 1'b1;
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[15:0] !== want.re || m_tdata[31:16] !== want.im
							|| m_tuser !== {want.ovf, want.dz, want.eq}) begin
						$display("%0t: mismatch expected re=%h im=%h eq=%b dz=%b ovf=%b",
							$time, want.re, want.im, want.eq, want.dz, want.ovf);
						$display("%0t:          actual   re=%h im=%h eq=%b dz=%b ovf=%b",
							$time, m_tdata[15:0], m_tdata[31:16], m_tuser[0], m_tuser[1],
							m_tuser[2]);
						failed = 1'b1;
					end
				end
			end
			if (in_fire || out_fire) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic queue_op(input logic [2:0] kind, input logic [15:0] ar, input logic [15:0] ai,
			input logic [15:0] br, input logic [15:0] bi);
		operand_pair_t op;
		op.kind = kind;
		op.ar = ar;
		op.ai = ai;
		op.br = br;
		op.bi = bi;
		pending_ops.push_back(op);
	endtask

	function automatic logic [15:0] random_part(input int style);
		case (style)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 1024)) - 512);
			2: return ($urandom_range(0, 1)) ? 16'h7fff : 16'h8000;
			default: return 16'($signed($urandom_range(0, 8)) - 4);
		endcase
	endfunction

	initial begin
		logic [2:0] kind;
		logic [15:0] ar, ai, br, bi;
		int style;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		m_tready = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		hold_off = 0;
		hold_armed = 1'b0;
		idle_cycles = 0;
		failed = 1'b0;
		in_fire = 1'b0;
		out_fire = 1'b0;
		stimulus_done = 1'b0;

		queue_op(cau_pkg::KIND_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
		queue_op(cau_pkg::KIND_ADD, 16'h0100, 16'hff00, 16'h0280, 16'h0040);
		queue_op(cau_pkg::KIND_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
		queue_op(cau_pkg::KIND_SUB, 16'h0300, 16'h0100, 16'h0100, 16'h0300);
		queue_op(cau_pkg::KIND_MUL, 16'h0200, 16'h0100, 16'h0100, 16'hff00);
		queue_op(cau_pkg::KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		queue_op(cau_pkg::KIND_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
		queue_op(cau_pkg::KIND_MUL, 16'h0001, 16'h0000, 16'h0080, 16'h0000);
		queue_op(cau_pkg::KIND_MUL, 16'hffff, 16'h0000, 16'h0080, 16'h0000);
		queue_op(cau_pkg::KIND_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
		queue_op(cau_pkg::KIND_DIV, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
		queue_op(cau_pkg::KIND_DIV, 16'h0200, 16'h0100, 16'h0100, 16'hff00);
		queue_op(cau_pkg::KIND_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
		queue_op(cau_pkg::KIND_DIV, 16'hff00, 16'h0100, 16'h8000, 16'h7fff);
		queue_op(cau_pkg::KIND_DIV, 16'h0005, 16'hfffb, 16'h0003, 16'h0000);
		queue_op(cau_pkg::KIND_CMP, 16'h1234, 16'h8000, 16'h1234, 16'h8000);
		queue_op(cau_pkg::KIND_CMP, 16'h1234, 16'h8000, 16'h1234, 16'h8001);
		queue_op(cau_pkg::KIND_CMP, 16'h7fff, 16'h0000, 16'h7ffe, 16'h0000);
		queue_op(KIND_UNUSED, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		queue_op(KIND_UNUSED_B, 16'h0100, 16'h0100, 16'h0100, 16'h0100);
		queue_op(KIND_UNUSED_C, 16'h8000, 16'h8000, 16'h8000, 16'h8000);

		for (int i = 0; i < 2000; i++) begin
			kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
			style = $urandom_range(0, 3);
			ar = random_part(style);
			ai = random_part(style);
			br = random_part(style);
			bi = random_part(style);
			if (kind == cau_pkg::KIND_CMP && $urandom_range(0, 1)) begin
				br = ar;
				bi = ai;
				if ($urandom_range(0, 2) == 0) bi[$urandom_range(0, 15)] ^= 1'b1;
			end
			if (kind == cau_pkg::KIND_DIV && $urandom_range(0, 15) == 0) begin
				br = '0;
				bi = '0;
			end
			queue_op(kind, ar, ai, br, bi);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_ops.size() == 0);
		wait (expected_results.size() == 0);
		repeat (2 * LATENCY) @(posedge clk);
		stimulus_done = 1'b1;
		if (failed || expected_results.size() != 0) begin
			$display("simulation failed");
		end else begin
			$display("simulation ok");
		end
		$finish;
	end
endmodule

### complex_arithmetic_unit_top.f
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_divider.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit_top.sv
tb/complex_arithmetic_unit_top_tb.sv
